// File: hdl/pf_pkg.sv
// Shared types and constants of the prime factorizer.
package pf_pkg;

   // Most factor words delivered for one input value.
   localparam int MAX_OUT = 31;
   localparam int COUNT_WIDTH = 5;
   localparam int FIRST_DIVISOR = 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_START,
      ST_DIVIDE,
      ST_DECIDE,
      ST_PUSH_DIV,
      ST_PUSH_REM,
      ST_EMIT
   } state_type;

   typedef enum logic {
      SRC_DIVISOR,
      SRC_REMAINING
   } factor_src_type;

   typedef struct packed {
      logic           load;
      logic           start_div;
      logic           next_divisor;
      logic           push;
      factor_src_type push_src;
      logic           emit_last;
   } cmd_type;

   typedef struct packed {
      logic below_two;
      logic div_busy;
      logic past_root;
      logic rem_zero;
      logic pend_valid;
      logic out_free;
      logic count_full;
   } status_type;

endpackage

// File: hdl/pf_channels.sv
// Valid/ready channel interfaces for the request and response words.
interface pf_req_if #(parameter int VALUE_WIDTH = 31) ();
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] value_in;

   modport source(output valid, output value_in, input ready);
   modport sink(input valid, input value_in, output ready);
endinterface

interface pf_rsp_if #(parameter int VALUE_WIDTH = 31) ();
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] factor;
   logic                   is_last;
   logic                   is_empty;

   modport source(output valid, output factor, output is_last, output is_empty, input ready);
   modport sink(input valid, input factor, input is_last, input is_empty, output ready);
endinterface

// File: hdl/pf_divider.sv
// Restoring divider that produces one quotient bit per clock.
module pf_divider #(
   parameter int DIVIDEND_WIDTH = 31,
   parameter int DIVISOR_WIDTH  = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [DIVIDEND_WIDTH-1:0] dividend,
   input  logic [DIVISOR_WIDTH-1:0]  divisor,
   output logic                      busy,
   output logic [DIVIDEND_WIDTH-1:0] quotient,
   output logic [DIVISOR_WIDTH-1:0]  remainder
);

   localparam int STEP_WIDTH = $clog2(DIVIDEND_WIDTH + 1);

   logic                      busy_ff, busy_in;
   logic [STEP_WIDTH-1:0]     step_ff, step_in;
   logic [DIVIDEND_WIDTH-1:0] quo_ff, quo_in;
   logic [DIVISOR_WIDTH-1:0]  rem_ff, rem_in;
   logic [DIVISOR_WIDTH:0]    trial;
   logic                      fits;

   // The partial remainder always stays below the divisor, so one extra bit suffices.
   assign trial = {rem_ff, quo_ff[DIVIDEND_WIDTH-1]};
   assign fits  = trial >= {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_WIDTH'(DIVIDEND_WIDTH);
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         step_in = step_ff - STEP_WIDTH'(1);
         quo_in  = {quo_ff[DIVIDEND_WIDTH-2:0], fits};
         rem_in  = fits ? DIVISOR_WIDTH'(trial - {1'b0, divisor})
                        : trial[DIVISOR_WIDTH-1:0];
         if (step_ff == STEP_WIDTH'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// File: hdl/pf_datapath.sv
// Datapath: remaining value, trial divisor, held-back factor and output register.
module pf_datapath #(
   parameter int VALUE_WIDTH = 31
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pf_pkg::cmd_type        cmd,
   input  logic [VALUE_WIDTH-1:0] value_in,
   output pf_pkg::status_type     status,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [VALUE_WIDTH-1:0] factor,
   output logic                   is_last,
   output logic                   is_empty
);

   // A trial divisor never passes the square root of the value plus one.
   localparam int DIV_WIDTH = VALUE_WIDTH / 2 + 1;

   logic [VALUE_WIDTH-1:0]         remaining_ff, remaining_in;
   logic [DIV_WIDTH-1:0]           divisor_ff, divisor_in;
   logic [VALUE_WIDTH-1:0]         pend_ff, pend_in;
   logic                           pend_valid_ff, pend_valid_in;
   logic [pf_pkg::COUNT_WIDTH-1:0] count_ff, count_in;
   logic                           out_valid_ff, out_valid_in;
   logic [VALUE_WIDTH-1:0]         out_factor_ff, out_factor_in;
   logic                           out_last_ff, out_last_in;
   logic                           out_empty_ff, out_empty_in;
   logic                           div_busy;
   logic [VALUE_WIDTH-1:0]         quotient;
   logic [DIV_WIDTH-1:0]           remainder;

   pf_divider #(
      .DIVIDEND_WIDTH(VALUE_WIDTH),
      .DIVISOR_WIDTH (DIV_WIDTH)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start_div),
      .dividend (remaining_ff),
      .divisor  (divisor_ff),
      .busy     (div_busy),
      .quotient (quotient),
      .remainder(remainder)
   );

   always_comb begin
      remaining_in  = remaining_ff;
      divisor_in    = divisor_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      count_in      = count_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_factor_in = out_factor_ff;
      out_last_in   = out_last_ff;
      out_empty_in  = out_empty_ff;

      if (cmd.load) begin
         remaining_in  = value_in;
         divisor_in    = DIV_WIDTH'(pf_pkg::FIRST_DIVISOR);
         pend_valid_in = 1'b0;
         count_in      = '0;
      end

      if (cmd.next_divisor) begin
         divisor_in = divisor_ff + DIV_WIDTH'(1);
      end

      // A new factor sends the held one out, since it is now known not to be last.
      if (cmd.push) begin
         if (pend_valid_ff) begin
            out_valid_in  = 1'b1;
            out_factor_in = pend_ff;
            out_last_in   = 1'b0;
            out_empty_in  = 1'b0;
         end
         if (cmd.push_src == pf_pkg::SRC_DIVISOR) begin
            pend_in      = VALUE_WIDTH'(divisor_ff);
            remaining_in = quotient;
         end else begin
            pend_in = remaining_ff;
         end
         pend_valid_in = 1'b1;
         count_in      = count_ff + pf_pkg::COUNT_WIDTH'(1);
      end

      if (cmd.emit_last) begin
         out_valid_in  = 1'b1;
         out_factor_in = pend_valid_ff ? pend_ff : '0;
         out_last_in   = 1'b1;
         out_empty_in  = !pend_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         count_ff      <= '0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         count_ff      <= count_in;
      end
      remaining_ff  <= remaining_in;
      divisor_ff    <= divisor_in;
      pend_ff       <= pend_in;
      out_factor_ff <= out_factor_in;
      out_last_ff   <= out_last_in;
      out_empty_ff  <= out_empty_in;
   end

   always_comb begin
      status.below_two  = remaining_ff < VALUE_WIDTH'(2);
      status.div_busy   = div_busy;
      status.past_root  = VALUE_WIDTH'(divisor_ff) > quotient;
      status.rem_zero   = remainder == '0;
      status.pend_valid = pend_valid_ff;
      status.out_free   = !out_valid_ff || rsp_ready;
      status.count_full = count_ff == pf_pkg::COUNT_WIDTH'(pf_pkg::MAX_OUT - 1);
   end

   assign rsp_valid = out_valid_ff;
   assign factor    = out_factor_ff;
   assign is_last   = out_last_ff;
   assign is_empty  = out_empty_ff;

endmodule

// File: hdl/pf_ctrl.sv
// Controller state machine that sequences the trial divisions.
module pf_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  pf_pkg::status_type status,
   output pf_pkg::cmd_type    cmd
);

   pf_pkg::state_type state_ff, state_in;
   logic              push_ok;

   // The held factor may only move on once the output register can take it.
   assign push_ok = !status.pend_valid || status.out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pf_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = pf_pkg::ST_CHECK;
            end
         end
         pf_pkg::ST_CHECK: begin
            state_in = status.below_two ? pf_pkg::ST_EMIT : pf_pkg::ST_START;
         end
         pf_pkg::ST_START: begin
            state_in = pf_pkg::ST_DIVIDE;
         end
         pf_pkg::ST_DIVIDE: begin
            if (!status.div_busy) begin
               state_in = pf_pkg::ST_DECIDE;
            end
         end
         pf_pkg::ST_DECIDE: begin
            if (status.past_root) begin
               state_in = status.below_two ? pf_pkg::ST_EMIT : pf_pkg::ST_PUSH_REM;
            end else if (status.rem_zero) begin
               state_in = pf_pkg::ST_PUSH_DIV;
            end else begin
               state_in = pf_pkg::ST_START;
            end
         end
         pf_pkg::ST_PUSH_DIV: begin
            if (push_ok) begin
               state_in = status.count_full ? pf_pkg::ST_EMIT : pf_pkg::ST_START;
            end
         end
         pf_pkg::ST_PUSH_REM: begin
            if (push_ok) begin
               state_in = pf_pkg::ST_EMIT;
            end
         end
         pf_pkg::ST_EMIT: begin
            if (status.out_free) begin
               state_in = pf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pf_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         pf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         pf_pkg::ST_START: begin
            cmd.start_div = 1'b1;
         end
         pf_pkg::ST_DECIDE: begin
            cmd.next_divisor = !status.past_root && !status.rem_zero;
         end
         pf_pkg::ST_PUSH_DIV: begin
            cmd.push     = push_ok;
            cmd.push_src = pf_pkg::SRC_DIVISOR;
         end
         pf_pkg::ST_PUSH_REM: begin
            cmd.push     = push_ok;
            cmd.push_src = pf_pkg::SRC_REMAINING;
         end
         pf_pkg::ST_EMIT: begin
            cmd.emit_last = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hdl/prime_factorizer.sv
// Top level of the trial-division prime factorizer.
//
//   Channel    Direction  Word contents
//   req_chan   in         value_in: the integer to factor
//   rsp_chan   out        factor, is_last, is_empty: one prime factor per word
//
// One input word is taken at a time; req_chan.ready is high only while the block is idle.
// Each trial divisor runs through the bit-serial divider (one quotient bit per clock);
// a prime near 2^31 needs about 46,340 trials, while small values need far fewer.
// Reset is synchronous and active high and returns the block to idle with no word pending.
// A stalled rsp_chan holds the last word; the search keeps running until a second
// factor is found, then waits for the output register to drain.
module prime_factorizer #(
   parameter int VALUE_WIDTH = 31
) (
   input logic             clock,
   input logic             reset,
   pf_req_if.sink          req_chan,
   pf_rsp_if.source        rsp_chan
);

   // Control flows from the state machine to the datapath as commands;
   // the datapath reports back with status flags only.
   pf_pkg::cmd_type    cmd;
   pf_pkg::status_type status;

   pf_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_chan.valid),
      .req_ready(req_chan.ready),
      .status   (status),
      .cmd      (cmd)
   );

   // Every factor is held back by one step, so that the word known to be final
   // can carry is_last. An input below two produces a single empty, last word.
   pf_datapath #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .value_in (req_chan.value_in),
      .status   (status),
      .rsp_valid(rsp_chan.valid),
      .rsp_ready(rsp_chan.ready),
      .factor   (rsp_chan.factor),
      .is_last  (rsp_chan.is_last),
      .is_empty (rsp_chan.is_empty)
   );

endmodule

// File: hdl/pf_checker.sv
// Port-level checker for the prime factorizer and its bind.
module pf_checker #(
   parameter int VALUE_WIDTH = 31
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [VALUE_WIDTH-1:0] factor,
   input logic                   is_last,
   input logic                   is_empty
);

   // A response word that is not taken stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word withdrawn while stalled");

   // An empty word always closes its input and carries no factor.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && is_empty |-> is_last && factor == '0)
      else $error("empty word without last mark or with a factor");

   // A real factor is at least two.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !is_empty |-> factor > VALUE_WIDTH'(1))
      else $error("factor below two");

   // Once a word is taken the block is busy with it on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("new request taken while factoring");

endmodule

bind prime_factorizer pf_checker #(
   .VALUE_WIDTH(VALUE_WIDTH)
) u_pf_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_chan.valid),
   .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .factor   (rsp_chan.factor),
   .is_last  (rsp_chan.is_last),
   .is_empty (rsp_chan.is_empty)
);
